FILE: src/lscc_pkg.sv
// Package for the legal scale and crop calculator.
// Holds the sequencer state type and register indexes; no dependencies.
package lscc_pkg;

    localparam int DIM_W   = 13;
    localparam int SCALE_W = 17;
    localparam int OFS_W   = 12;
    localparam int NUM_W   = 22;

    localparam logic [0:0] REG_TARGET_WIDTH  = 1'b0;
    localparam logic [0:0] REG_TARGET_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_KW,
        ST_DIV_KH,
        ST_GCD,
        ST_SCAN,
        ST_DIV_CW,
        ST_DIV_CH,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [NUM_W-1:0] rem;
    } div_rsp_t;

endpackage

FILE: src/lscc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lscc_pkg.
module lscc_div
    import lscc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = NUM_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[NUM_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: src/legal_scale_crop_calc.sv
// Channel   | handshake            | payload
// request   | in_valid / in_ready  | source_width, source_height
// result    | out_valid / out_ready| valid_res, exact, scale_steps, crop, offsets
// config    | cfg_we               | cfg_index, cfg_data
//
// Each request runs its divides on the single shared divider, in order:
// two for the minimum scale, one per gcd remainder step, one per scan
// candidate i up to sqrt(gcd) (at most 362 with FRAC_STEPS of 16) and two
// for the crop.
// Reset clears the target registers and the sequencer. in_ready is low from
// acceptance until the result is taken; out_ready low holds the result.
// Depends on lscc_pkg and lscc_div.
module legal_scale_crop_calc
    import lscc_pkg::*;
#(
    parameter int FRAC_STEPS = 16,
    parameter int INT_LIMIT  = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [DIM_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DIM_W-1:0]   source_width,
    input  logic [DIM_W-1:0]   source_height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic               exact,
    output logic [SCALE_W-1:0] scale_steps,
    output logic [DIM_W-1:0]   crop_width,
    output logic [DIM_W-1:0]   crop_height,
    output logic [OFS_W-1:0]   offset_x,
    output logic [OFS_W-1:0]   offset_y
);

    localparam logic [NUM_W-1:0] FRAC = NUM_W'(FRAC_STEPS);
    localparam logic [NUM_W-1:0] KMAX = NUM_W'(INT_LIMIT * FRAC_STEPS - 1);
    localparam logic [NUM_W-1:0] SMAX = NUM_W'(131071);

    state_t state_reg, state_next;
    logic [DIM_W-1:0]   tw_reg, th_reg, sw_reg, sh_reg;
    logic [NUM_W-1:0]   kmin_reg, kmin_next;
    logic [NUM_W-1:0]   ga_reg, ga_next, gb_reg, gb_next;
    logic [NUM_W-1:0]   i_reg, i_next, k_reg, k_next;
    logic [DIM_W-1:0]   cw_reg, cw_next, ch_reg, ch_next;
    logic               ex_reg, ex_next, vres_reg, vres_next;
    logic               pend_reg, pend_next;
    logic [2*NUM_W-1:0] isq;
    logic [NUM_W-1:0]   twq, thq, cand_hi, kmin_c, kfin;
    logic [DIM_W-1:0]   cwc, chc;
    logic               exf;
    div_req_t dreq;
    div_rsp_t drsp;

    lscc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign twq = NUM_W'(tw_reg) * FRAC;
    assign thq = NUM_W'(th_reg) * FRAC;
    assign isq = i_reg * i_reg;
    assign cand_hi = drsp.quot;
    assign kfin = (k_reg == '0) ? kmin_reg : k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= '0;
            th_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TARGET_WIDTH)
                tw_reg <= cfg_data;
            else
                th_reg <= cfg_data;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (source_width == '0 || source_height == '0 ||
                        tw_reg == '0 || th_reg == '0)
                        state_next = ST_OUT;
                    else
                        state_next = ST_DIV_KW;
                end
            ST_DIV_KW: if (drsp.done) state_next = ST_DIV_KH;
            ST_DIV_KH: if (drsp.done) state_next = ST_GCD;
            ST_GCD:
                if (!pend_reg && gb_reg == '0)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (!pend_reg && isq > {{NUM_W{1'b0}}, ga_reg})
                    state_next = ST_DIV_CW;
            ST_DIV_CW: if (drsp.done) state_next = ST_DIV_CH;
            ST_DIV_CH: if (drsp.done) state_next = ST_DONE;
            ST_DONE: state_next = ST_OUT;
            ST_OUT: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and divider requests
    always_comb
    begin
        kmin_next = kmin_reg;
        ga_next   = ga_reg;
        gb_next   = gb_reg;
        i_next    = i_reg;
        k_next    = k_reg;
        cw_next   = cw_reg;
        ch_next   = ch_reg;
        ex_next   = ex_reg;
        vres_next = vres_reg;
        pend_next = pend_reg;
        dreq      = '0;
        kmin_c    = kmin_reg;
        cwc       = cw_reg;
        chc       = ch_reg;
        exf       = ex_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    vres_next = !(source_width == '0 || source_height == '0 ||
                                  tw_reg == '0 || th_reg == '0);
                    ex_next = 1'b0;
                    k_next  = '0;
                    cw_next = '0;
                    ch_next = '0;
                    kmin_next = '0;
                    if (vres_next)
                    begin
                        // ceil(twq/sw) as (twq+sw-1)/sw
                        dreq.start = 1'b1;
                        dreq.num = twq + NUM_W'(source_width) - 1'b1;
                        dreq.den = NUM_W'(source_width);
                    end
                end
            ST_DIV_KW:
                if (drsp.done)
                begin
                    kmin_next  = drsp.quot;
                    dreq.start = 1'b1;
                    dreq.num   = thq + NUM_W'(sh_reg) - 1'b1;
                    dreq.den   = NUM_W'(sh_reg);
                end
            ST_DIV_KH:
                if (drsp.done)
                begin
                    kmin_c = (drsp.quot > kmin_reg) ? drsp.quot : kmin_reg;
                    if (kmin_c < NUM_W'(1)) kmin_c = NUM_W'(1);
                    if (kmin_c > KMAX) kmin_c = KMAX;
                    kmin_next = kmin_c;
                    ga_next = twq;
                    gb_next = thq;
                    pend_next = 1'b0;
                end
            ST_GCD:
                if (pend_reg)
                begin
                    if (drsp.done)
                    begin
                        ga_next = gb_reg;
                        gb_next = drsp.rem;
                        pend_next = 1'b0;
                    end
                end
                else if (gb_reg != '0)
                begin
                    dreq.start = 1'b1;
                    dreq.num = ga_reg;
                    dreq.den = gb_reg;
                    pend_next = 1'b1;
                end
                else
                    i_next = NUM_W'(1);
            ST_SCAN:
                if (pend_reg)
                begin
                    if (drsp.done)
                    begin
                        pend_next = 1'b0;
                        if (drsp.rem == '0)
                        begin
                            if (i_reg >= kmin_reg && i_reg <= SMAX &&
                                (k_reg == '0 || i_reg < k_reg))
                                k_next = i_reg;
                            // low divisor first, then the paired one
                            if (cand_hi >= kmin_reg && cand_hi <= SMAX &&
                                ((k_reg == '0 && !(i_reg >= kmin_reg && i_reg <= SMAX)) ||
                                 cand_hi < ((k_next == '0) ? cand_hi + 1'b1 : k_next)))
                                k_next = cand_hi;
                        end
                        i_next = i_reg + 1'b1;
                    end
                end
                else if (isq <= {{NUM_W{1'b0}}, ga_reg})
                begin
                    dreq.start = 1'b1;
                    dreq.num = ga_reg;
                    dreq.den = i_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    ex_next = (k_reg != '0);
                    k_next = kfin;
                    dreq.start = 1'b1;
                    dreq.num = twq;
                    dreq.den = kfin;
                end
            ST_DIV_CW:
                if (drsp.done)
                begin
                    cw_next = DIM_W'(drsp.quot);
                    dreq.start = 1'b1;
                    dreq.num = thq;
                    dreq.den = k_reg;
                end
            ST_DIV_CH:
                if (drsp.done)
                    ch_next = DIM_W'(drsp.quot);
            ST_DONE:
            begin
                cwc = cw_reg;
                chc = ch_reg;
                exf = ex_reg;
                if (cwc == '0) begin cwc = DIM_W'(1); exf = 1'b0; end
                if (chc == '0) begin chc = DIM_W'(1); exf = 1'b0; end
                if (cwc > sw_reg || chc > sh_reg)
                begin
                    cwc = sw_reg;
                    chc = sh_reg;
                    exf = 1'b0;
                end
                cw_next = cwc;
                ch_next = chc;
                ex_next = exf;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            sw_reg <= source_width;
            sh_reg <= source_height;
        end
        kmin_reg <= kmin_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        cw_reg   <= cw_next;
        ch_reg   <= ch_next;
        ex_reg   <= ex_next;
        vres_reg <= vres_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign valid_res   = vres_reg;
    assign exact       = vres_reg & ex_reg;
    assign scale_steps = vres_reg ? SCALE_W'(k_reg) : '0;
    assign crop_width  = cw_reg;
    assign crop_height = ch_reg;
    assign offset_x    = vres_reg ? OFS_W'((sw_reg - cw_reg) >> 1) : '0;
    assign offset_y    = vres_reg ? OFS_W'((sh_reg - ch_reg) >> 1) : '0;

endmodule

FILE: src/lscc_checker.sv
// Port-level checks for the legal scale and crop calculator.
// Depends on lscc_pkg; bound to legal_scale_crop_calc.
module lscc_checker
    import lscc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               valid_res,
    input logic               exact,
    input logic [SCALE_W-1:0] scale_steps,
    input logic [DIM_W-1:0]   crop_width
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> !exact && scale_steps == '0 && crop_width == '0)
        else $error("invalid result carries data");

    a_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> scale_steps != '0 && crop_width != '0)
        else $error("zero scale or crop");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scale_steps))
        else $error("result dropped");

endmodule

bind legal_scale_crop_calc lscc_checker u_lscc_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .valid_res(valid_res), .exact(exact),
    .scale_steps(scale_steps), .crop_width(crop_width)
);

FILE: bench/legal_scale_crop_calc_test.sv
// Self-checking bench for legal_scale_crop_calc: directed and random frame sizes
// over several target sizes. Depends on lscc_pkg and the block's RTL.
module legal_scale_crop_calc_test;
    import lscc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = 16;
    localparam int INT_LIM  = 255;
    localparam int SCALE_MAX = 131071;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic               valid_res;
        logic               exact;
        logic [SCALE_W-1:0] scale_steps;
        logic [DIM_W-1:0]   crop_width;
        logic [DIM_W-1:0]   crop_height;
        logic [OFS_W-1:0]   offset_x;
        logic [OFS_W-1:0]   offset_y;
    } crop_result_t;

    class crop_scoreboard;
        int unsigned tgt_w;
        int unsigned tgt_h;
        crop_result_t pending[$];
        int errors;
        int requests;
        int results;
        int exact_seen;
        int invalid_seen;

        function new();
            tgt_w = 0;
            tgt_h = 0;
            errors = 0;
            requests = 0;
            results = 0;
            exact_seen = 0;
            invalid_seen = 0;
        endfunction

        function crop_result_t compute_crop(int unsigned sw, int unsigned sh);
            crop_result_t r;
            int unsigned twq, thq, kmin, kmax, kw, kh, g, a, b, t, k, i, cw, ch;
            bit ex;
            r = '0;
            if (sw == 0 || sh == 0 || tgt_w == 0 || tgt_h == 0)
                return r;
            twq = tgt_w * FRAC;
            thq = tgt_h * FRAC;
            kmax = INT_LIM * FRAC - 1;
            kw = (twq + sw - 1) / sw;
            kh = (thq + sh - 1) / sh;
            kmin = (kw > kh) ? kw : kh;
            if (kmin < 1)
                kmin = 1;
            if (kmin > kmax)
                kmin = kmax;
            a = twq;
            b = thq;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            g = a;
            k = 0;
            for (i = 1; i * i <= g; i++)
            begin
                if (g % i != 0)
                    continue;
                if (i >= kmin && i <= SCALE_MAX && (k == 0 || i < k))
                    k = i;
                if (g / i >= kmin && g / i <= SCALE_MAX && (k == 0 || g / i < k))
                    k = g / i;
            end
            ex = 1;
            if (k == 0)
            begin
                k = kmin;
                ex = 0;
            end
            cw = twq / k;
            ch = thq / k;
            if (cw < 1)
            begin
                cw = 1;
                ex = 0;
            end
            if (ch < 1)
            begin
                ch = 1;
                ex = 0;
            end
            if (cw > sw || ch > sh)
            begin
                cw = sw;
                ch = sh;
                ex = 0;
            end
            r.valid_res   = 1'b1;
            r.exact       = ex;
            r.scale_steps = k[SCALE_W-1:0];
            r.crop_width  = cw[DIM_W-1:0];
            r.crop_height = ch[DIM_W-1:0];
            r.offset_x    = OFS_W'((sw - cw) / 2);
            r.offset_y    = OFS_W'((sh - ch) / 2);
            return r;
        endfunction

        function void note_request(int unsigned sw, int unsigned sh);
            pending.push_back(compute_crop(sw, sh));
            requests++;
        endfunction

        function void check_result(crop_result_t got);
            crop_result_t want;
            results++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.valid_res)
                exact_seen += got.exact;
            else
                invalid_seen++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected %p, got %p", results, want, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [DIM_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [DIM_W-1:0]   source_width;
    logic [DIM_W-1:0]   source_height;
    logic               out_valid;
    logic               out_ready;
    crop_result_t       res_bus;

    crop_scoreboard sb = new();
    int idle_cycles;

    legal_scale_crop_calc dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .source_width  (source_width),
        .source_height (source_height),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .valid_res     (res_bus.valid_res),
        .exact         (res_bus.exact),
        .scale_steps   (res_bus.scale_steps),
        .crop_width    (res_bus.crop_width),
        .crop_height   (res_bus.crop_height),
        .offset_x      (res_bus.offset_x),
        .offset_y      (res_bus.offset_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(int unsigned tgt);
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return DIM_W'($urandom_range(1, 64));
            3: return DIM_W'(tgt + $urandom_range(0, 8));
            4: return 13'h1FFF;
            default: return DIM_W'($urandom_range(1, 8191));
        endcase
    endfunction

    task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TARGET_WIDTH)
            sb.tgt_w = val;
        else
            sb.tgt_h = val;
    endtask

    // Change targets only once the block has drained.
    task automatic set_targets(logic [DIM_W-1:0] tw, logic [DIM_W-1:0] th);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
    endtask

    task automatic send_request(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        source_width  <= sw;
        source_height <= sh;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(sw, sh);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            send_request(pick_dim(sb.tgt_w), pick_dim(sb.tgt_h));
    endtask

    // Receiver: check accepted results, stall at random, hold off once for long.
    initial
    begin
        bit held;
        int gap;
        held = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(res_bus);
            if (!held && sb.results == 60)
            begin
                held = 1;
                out_ready <= 1'b0;
                repeat (4000) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
                @(posedge clk);
                if (out_valid && out_ready)
                    sb.check_result(res_bus);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("legal_scale_crop_calc: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        source_width  = '0;
        source_height = '0;
        idle_cycles   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Targets still at reset: every result is invalid.
        send_request(1920, 1080);
        send_request(8191, 8191);

        set_targets(1920, 1080);
        send_request(0, 5);
        send_request(5, 0);
        send_request(1, 1);
        send_request(8191, 8191);
        send_request(1920, 1080);
        send_request(3840, 2160);
        send_request(1, 8191);
        send_request(8191, 1);
        send_request(960, 540);
        send_request(1000, 1000);
        send_request(7, 3);
        send_request(4096, 2048);
        run_random(60);

        set_targets(0, 100);
        run_random(4);
        set_targets(100, 0);
        run_random(4);
        // Largest gcd: long divisor scan, keep this phase short.
        set_targets(8191, 8191);
        send_request(1, 1);
        send_request(8191, 8191);
        run_random(3);
        set_targets(1, 1);
        send_request(8191, 8191);
        run_random(30);
        set_targets(8191, 1);
        run_random(25);
        set_targets(1, 8191);
        run_random(25);
        set_targets(640, 480);
        run_random(50);
        for (int p = 0; p < 4; p++)
        begin
            set_targets(DIM_W'($urandom_range(1, 8191)), DIM_W'($urandom_range(1, 8191)));
            run_random(20);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d requests over 13 target settings: %0d exact, %0d invalid",
                 sb.requests, sb.exact_seen, sb.invalid_seen);
        if (sb.errors == 0)
            $display("legal_scale_crop_calc: match");
        else
            $display("legal_scale_crop_calc: mismatch");
        $finish;
    end

endmodule
